[rtl/core/spq_pkg.sv]
package spq_pkg;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] key;
      logic [31:0] priority_req;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] out_key;
      logic [31:0] out_priority;
      logic [4:0]  count;
   } rsp_type;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] prio;
   } entry_type;

   typedef struct packed {
      logic        do_insert;
      logic        do_pop;
      logic        do_remove;
      logic [31:0] key;
      logic [31:0] prio;
   } cmd_type;

endpackage

[rtl/core/spq_cell.sv]
module spq_cell (
   input  logic               clock,
   input  spq_pkg::cmd_type   cmd,
   input  logic               valid_self,
   input  spq_pkg::entry_type left_entry,
   input  logic               left_le,
   input  logic               seen_in,
   input  spq_pkg::entry_type right_entry,
   output spq_pkg::entry_type entry,
   output logic               le_out,
   output logic               seen_out,
   output spq_pkg::entry_type hit_entry
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;
   logic               match;

   assign le_out    = valid_self && (entry_ff.prio <= cmd.prio);
   assign match     = valid_self && (entry_ff.key == cmd.key);
   assign seen_out  = seen_in || match;
   assign hit_entry = (match && !seen_in) ? entry_ff : '0;
   assign entry     = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.do_insert) begin
         if (!le_out) begin
            if (left_le) begin
               entry_in.key  = cmd.key;
               entry_in.prio = cmd.prio;
            end else begin
               entry_in = left_entry;
            end
         end
      end else if (cmd.do_pop) begin
         entry_in = right_entry;
      end else if (cmd.do_remove && seen_out) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

[rtl/core/sorted_priority_queue_top.sv]
// Sorted priority queue of up to CAPACITY (key, priority) entries.
// The request channel (req_valid, req_stall, req_data) carries one
// operation per beat: insert, pop smallest, or remove by key. Equal
// priorities are served first in, first out.
// The response channel (rsp_valid, rsp_stall, rsp_data) returns exactly
// one beat per request with a status, the popped or removed entry, and
// the entry count after the operation.
// Each entry lives in one cell of a chain; all cells compare against the
// request in parallel and shift toward or away from their neighbors in the
// same cycle. The response is registered and appears in the cycle after the
// request beat, and one request is taken every cycle while the response
// side keeps up.
// Reset empties the queue and drops any pending response.
// When the receiver stalls, the response is held in the output register
// and req_stall is raised until that response is taken.
module sorted_priority_queue_top #(
   parameter int CAPACITY = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output spq_pkg::rsp_type rsp_data
);

   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0]      fill_ff;
   logic [CW-1:0]      fill_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   spq_pkg::rsp_type   rsp_ff;
   spq_pkg::rsp_type   rsp_in;
   spq_pkg::cmd_type   cmd;
   logic               accept;
   logic               full;
   logic               empty;
   logic               found;
   spq_pkg::entry_type hit_sum;

   spq_pkg::entry_type entries [CAPACITY];
   spq_pkg::entry_type hits    [CAPACITY];
   logic [CAPACITY-1:0] le;
   logic [CAPACITY-1:0] seen;
   logic [CAPACITY-1:0] valid;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = (fill_ff == CW'(CAPACITY));
   assign empty     = (fill_ff == '0);
   assign found     = seen[CAPACITY-1];

   assign cmd.do_insert = accept && (req_data.op == spq_pkg::OP_INSERT) && !full;
   assign cmd.do_pop    = accept && (req_data.op == spq_pkg::OP_POP) && !empty;
   assign cmd.do_remove = accept && (req_data.op == spq_pkg::OP_REMOVE) && found;
   assign cmd.key       = req_data.key;
   assign cmd.prio      = req_data.priority_req;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign valid[i] = (CW'(i) < fill_ff);
      spq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .valid_self  (valid[i]),
         .left_entry  ((i == 0) ? entries[0] : entries[(i == 0) ? 0 : i - 1]),
         .left_le     ((i == 0) ? 1'b1 : le[(i == 0) ? 0 : i - 1]),
         .seen_in     ((i == 0) ? 1'b0 : seen[(i == 0) ? 0 : i - 1]),
         .right_entry (entries[(i == CAPACITY - 1) ? i : i + 1]),
         .entry       (entries[i]),
         .le_out      (le[i]),
         .seen_out    (seen[i]),
         .hit_entry   (hits[i])
      );
   end

   always_comb begin
      hit_sum = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit_sum = hit_sum | hits[i];
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (cmd.do_insert) begin
         fill_in = fill_ff + CW'(1);
      end else if (cmd.do_pop || cmd.do_remove) begin
         fill_in = fill_ff - CW'(1);
      end
   end

   always_comb begin
      rsp_in              = rsp_ff;
      rsp_valid_in        = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in        = 1'b1;
         rsp_in.status       = spq_pkg::ST_OK;
         rsp_in.out_key      = '0;
         rsp_in.out_priority = '0;
         rsp_in.count        = 5'(fill_in);
         case (req_data.op)
            spq_pkg::OP_INSERT: begin
               if (full) begin
                  rsp_in.status = spq_pkg::ST_FULL;
               end
            end
            spq_pkg::OP_POP: begin
               if (empty) begin
                  rsp_in.status = spq_pkg::ST_EMPTY;
               end else begin
                  rsp_in.out_key      = entries[0].key;
                  rsp_in.out_priority = entries[0].prio;
               end
            end
            spq_pkg::OP_REMOVE: begin
               if (found) begin
                  rsp_in.out_key      = hit_sum.key;
                  rsp_in.out_priority = hit_sum.prio;
               end else begin
                  rsp_in.status = spq_pkg::ST_NOT_FOUND;
               end
            end
            default: begin
               rsp_in.status = spq_pkg::ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/core/spq_checker.sv]
module spq_checker #(
   parameter int CAPACITY = 16
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input spq_pkg::rsp_type rsp_data
);

   // A response beat held by the receiver must not change.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // Every accepted request produces a response beat in the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request produced no response");

   // The request side stalls only behind a pending response.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a blocked response");

   // A full refusal reports a full queue.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == spq_pkg::ST_FULL) |->
         (rsp_data.count == 5'(CAPACITY)))
      else $error("full status with wrong count");

   // An empty pop reports an empty queue and no entry.
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == spq_pkg::ST_EMPTY) |->
         (rsp_data.count == 5'd0) && (rsp_data.out_key == 32'd0))
      else $error("empty status with entries reported");

endmodule

bind sorted_priority_queue_top spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (.*);

[sim/sorted_priority_queue_top_test.sv]
module sorted_priority_queue_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY = 16;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 2000;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   spq_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   spq_pkg::rsp_type rsp_data;

   spq_pkg::entry_type queue_cells [CAPACITY];
   int                 queue_fill;
   spq_pkg::rsp_type   expected_rsps [$];
   int                 error_count;
   int                 stall_left;
   int                 quiet_cycles;
   bit                 idle_on;

   sorted_priority_queue_top #(
      .CAPACITY(CAPACITY)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #5 clock = ~clock;

   task automatic drop_cell(input int pos);
      for (int i = pos; i + 1 < queue_fill; i++) begin
         queue_cells[i] = queue_cells[i + 1];
      end
      queue_fill--;
   endtask

   // Applies one accepted operation to the local copy of the queue and
   // queues the response that the block must return for it.
   task automatic predict_queue_op(input spq_pkg::req_type item);
      spq_pkg::rsp_type res;
      int               pos;
      int               hit;
      res = '0;
      res.status = spq_pkg::ST_OK;
      case (item.op)
         spq_pkg::OP_INSERT: begin
            if (queue_fill >= CAPACITY) begin
               res.status = spq_pkg::ST_FULL;
            end else begin
               pos = 0;
               while (pos < queue_fill && queue_cells[pos].prio <= item.priority_req) pos++;
               for (int i = queue_fill; i > pos; i--) begin
                  queue_cells[i] = queue_cells[i - 1];
               end
               queue_cells[pos].key = item.key;
               queue_cells[pos].prio = item.priority_req;
               queue_fill++;
            end
         end
         spq_pkg::OP_POP: begin
            if (queue_fill == 0) begin
               res.status = spq_pkg::ST_EMPTY;
            end else begin
               res.out_key = queue_cells[0].key;
               res.out_priority = queue_cells[0].prio;
               drop_cell(0);
            end
         end
         spq_pkg::OP_REMOVE: begin
            hit = -1;
            for (int i = 0; i < queue_fill; i++) begin
               if (hit < 0 && queue_cells[i].key == item.key) hit = i;
            end
            if (hit < 0) begin
               res.status = spq_pkg::ST_NOT_FOUND;
            end else begin
               res.out_key = queue_cells[hit].key;
               res.out_priority = queue_cells[hit].prio;
               drop_cell(hit);
            end
         end
         default: begin
         end
      endcase
      res.count = queue_fill[4:0];
      expected_rsps.push_back(res);
   endtask

   function automatic spq_pkg::req_type make_req(input logic [1:0] op,
                                                 input logic [31:0] key,
                                                 input logic [31:0] prio);
      spq_pkg::req_type item;
      item.op = op;
      item.key = key;
      item.priority_req = prio;
      return item;
   endfunction

   task automatic send_op(input spq_pkg::req_type item);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 7);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      predict_queue_op(item);
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_prio();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         3, 4, 5: return $urandom_range(0, 7);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] rand_key();
      if ($urandom_range(0, 1) == 0) return $urandom_range(0, 15);
      return $urandom;
   endfunction

   // Mostly picks a key that is stored right now, so removes usually hit.
   function automatic logic [31:0] remove_key();
      if (queue_fill > 0 && $urandom_range(0, 9) < 7) begin
         return queue_cells[$urandom_range(0, queue_fill - 1)].key;
      end
      return rand_key();
   endfunction

   function automatic spq_pkg::req_type rand_req(input int insert_weight);
      int               roll;
      spq_pkg::req_type item;
      roll = $urandom_range(0, 99);
      if (roll < 3) item = make_req(OP_UNUSED, $urandom, $urandom);
      else if (roll < 3 + insert_weight) begin
         item = make_req(spq_pkg::OP_INSERT, rand_key(), rand_prio());
      end else if (roll < 3 + insert_weight + (97 - insert_weight) / 2) begin
         item = make_req(spq_pkg::OP_POP, $urandom, $urandom);
      end else begin
         item = make_req(spq_pkg::OP_REMOVE, remove_key(), $urandom);
      end
      return item;
   endfunction

   task automatic test_empty_queue();
      send_op(make_req(spq_pkg::OP_POP, 32'h0, 32'h0));
      send_op(make_req(spq_pkg::OP_REMOVE, 32'h0, 32'h0));
      send_op(make_req(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
   endtask

   // Extreme keys and priorities, first in first out among equal priorities,
   // a remove of a duplicated key, a remove from the middle and a miss.
   task automatic test_order_and_ties();
      send_op(make_req(spq_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_op(make_req(spq_pkg::OP_INSERT, 32'h0000_0000, 32'h0000_0000));
      send_op(make_req(spq_pkg::OP_INSERT, 32'hA1, 32'd5));
      send_op(make_req(spq_pkg::OP_INSERT, 32'hA2, 32'd5));
      send_op(make_req(spq_pkg::OP_INSERT, 32'hA3, 32'd5));
      send_op(make_req(spq_pkg::OP_INSERT, 32'hD0, 32'd9));
      send_op(make_req(spq_pkg::OP_INSERT, 32'hD0, 32'd3));
      send_op(make_req(spq_pkg::OP_REMOVE, 32'hD0, 32'h0));
      send_op(make_req(spq_pkg::OP_REMOVE, 32'hA2, 32'h0));
      send_op(make_req(spq_pkg::OP_REMOVE, 32'h1234, 32'h0));
      send_op(make_req(OP_UNUSED, 32'h5555_AAAA, 32'hAAAA_5555));
      repeat (6) send_op(make_req(spq_pkg::OP_POP, 32'h0, 32'h0));
   endtask

   task automatic test_fill_and_drain();
      repeat (3) begin
         while (queue_fill < CAPACITY) begin
            send_op(make_req(spq_pkg::OP_INSERT, rand_key(), rand_prio()));
         end
         send_op(make_req(spq_pkg::OP_INSERT, $urandom, $urandom));
         send_op(make_req(spq_pkg::OP_INSERT, rand_key(), rand_prio()));
         send_op(make_req(OP_UNUSED, $urandom, $urandom));
         while (queue_fill > 0) begin
            if ($urandom_range(0, 1) == 0) begin
               send_op(make_req(spq_pkg::OP_POP, $urandom, $urandom));
            end else begin
               send_op(make_req(spq_pkg::OP_REMOVE, remove_key(), $urandom));
            end
         end
         send_op(make_req(spq_pkg::OP_POP, $urandom, $urandom));
      end
   endtask

   task automatic test_random_mix();
      int weight;
      repeat (6) begin
         case ($urandom_range(0, 2))
            0: weight = 65;
            1: weight = 40;
            default: weight = 20;
         endcase
         repeat (90) send_op(rand_req(weight));
      end
   endtask

   task automatic test_pause_until_drained();
      repeat (3) begin
         repeat ($urandom_range(3, 8)) send_op(rand_req(50));
         hold_until_drained();
      end
   endtask

   task automatic test_back_to_back();
      idle_on = 1'b0;
      repeat (150) send_op(rand_req(45));
   endtask

   always @(negedge clock) begin
      if (idle_on && stall_left == 0 && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 7);
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      spq_pkg::rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response beat, expected none, actual %p", $time, rsp_data);
            error_count++;
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_data.status !== exp_rsp.status) begin
               $display("%0t: status expected %0d actual %0d", $time, exp_rsp.status,
                        rsp_data.status);
               error_count++;
            end
            if (rsp_data.out_key !== exp_rsp.out_key) begin
               $display("%0t: out_key expected %h actual %h", $time, exp_rsp.out_key,
                        rsp_data.out_key);
               error_count++;
            end
            if (rsp_data.out_priority !== exp_rsp.out_priority) begin
               $display("%0t: out_priority expected %h actual %h", $time,
                        exp_rsp.out_priority, rsp_data.out_priority);
               error_count++;
            end
            if (rsp_data.count !== exp_rsp.count) begin
               $display("%0t: count expected %0d actual %0d", $time, exp_rsp.count,
                        rsp_data.count);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      queue_fill = 0;
      error_count = 0;
      stall_left = 0;
      quiet_cycles = 0;
      idle_on = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_order_and_ties();
      test_fill_and_drain();
      test_pause_until_drained();
      test_random_mix();
      test_back_to_back();

      hold_until_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
